// File: rtl/mrcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcs_pkg
// Shared types and constants for the matrix row and column sum block.
// ----------------------------------------------------------------------------
package mrcs_pkg;

   localparam int MAX_COLS_DEF = 32;

   localparam int ELEM_W  = 32;
   localparam int SUM_W   = 40;
   localparam int ROWS_W  = 16;
   localparam int COLS_W  = 6;
   localparam int INDEX_W = 16;
   localparam int KIND_W  = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [KIND_W-1:0] {
      SUM_ROW = 2'd0,
      SUM_COL = 2'd1,
      SUM_ERR = 2'd2
   } sum_kind_type;

   typedef enum logic {
      ST_RUN   = 1'b0,
      ST_DRAIN = 1'b1
   } ctrl_state_type;

   typedef enum logic {
      CSR_NUM_ROWS = 1'b0,
      CSR_NUM_COLS = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [ROWS_W-1:0] num_rows;
      logic [COLS_W-1:0] num_cols;
   } mrcs_cfg_type;

   typedef struct packed {
      sum_kind_type              kind;
      logic [INDEX_W-1:0]        index;
      logic signed [SUM_W-1:0]   value;
      logic                      last;
   } mrcs_rsp_type;

   typedef struct packed {
      logic              err;
      logic              first_row;
      logic              row_end;
      logic              matrix_end;
      logic [ROWS_W-1:0] row_idx;
   } mrcs_item_type;

endpackage

// File: rtl/mrcs_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcs_csr
// Register file for the matrix dimensions, written over the apb-style port.
// ----------------------------------------------------------------------------
module mrcs_csr import mrcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output mrcs_cfg_type          cfg
);

   logic [ROWS_W-1:0] num_rows_ff, num_rows_in;
   logic [COLS_W-1:0] num_cols_ff, num_cols_in;
   csr_reg_type       reg_sel;
   logic              wr_en;

   // registers sit on 4-byte boundaries, bit 2 picks one
   assign reg_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_NUM_ROWS: num_rows_in = csr_pwdata[ROWS_W-1:0];
            CSR_NUM_COLS: num_cols_in = csr_pwdata[COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_NUM_ROWS: csr_prdata = {{(CSR_DATA_W-ROWS_W){1'b0}}, num_rows_ff};
         CSR_NUM_COLS: csr_prdata = {{(CSR_DATA_W-COLS_W){1'b0}}, num_cols_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= ROWS_W'(1);
         num_cols_ff <= COLS_W'(1);
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   assign cfg.num_rows = num_rows_ff;
   assign cfg.num_cols = num_cols_ff;

endmodule

// File: rtl/mrcs_col_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcs_col_mem
// Column total store: one write and one registered read port, with bypass
// of a write that lands on the entry being read in the same cycle.
// ----------------------------------------------------------------------------
module mrcs_col_mem import mrcs_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  logic [SUM_W-1:0]    wdata,
   input  logic                re,
   input  logic [AW-1:0]       raddr,
   output logic [SUM_W-1:0]    rdata
);

   logic [SUM_W-1:0] mem [MAX_COLS];
   logic [SUM_W-1:0] rdata_ff;
   logic [SUM_W-1:0] fwd_data_ff;
   logic             fwd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff    <= mem[raddr];
         fwd_data_ff <= wdata;
      end
   end

   // read and write on the same entry at one edge: array gives the old value
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (re) begin
         fwd_ff <= we && (waddr == raddr);
      end
   end

   assign rdata = fwd_ff ? fwd_data_ff : rdata_ff;

endmodule

// File: rtl/mrcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcs_ctrl
// Position tracking, read-modify-write of the column store, row sums,
// column drain sequencing and the response register.
// ----------------------------------------------------------------------------
module mrcs_ctrl import mrcs_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  mrcs_cfg_type        cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ELEM_W-1:0]   req_element,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output mrcs_rsp_type        rsp_item,
   output logic                mem_we,
   output logic [AW-1:0]       mem_waddr,
   output logic [SUM_W-1:0]    mem_wdata,
   output logic                mem_re,
   output logic [AW-1:0]       mem_raddr,
   input  logic [SUM_W-1:0]    mem_rdata
);

   localparam logic [COLS_W:0] MAX_COLS_W = (COLS_W+1)'(MAX_COLS);
   localparam logic [AW-1:0]   LAST_COL   = AW'(MAX_COLS - 1);

   ctrl_state_type      state_ff, state_in;
   logic [COLS_W-1:0]   col_pos_ff, col_pos_in;
   logic [ROWS_W-1:0]   row_pos_ff, row_pos_in;
   logic [SUM_W-1:0]    row_total_ff, row_total_in;
   logic [AW-1:0]       drain_idx_ff, drain_idx_in;
   logic                s1_valid_ff, s1_valid_in;
   logic [ELEM_W-1:0]   s1_elem_ff, s1_elem_in;
   logic [AW-1:0]       s1_col_ff, s1_col_in;
   mrcs_item_type       s1_item_ff, s1_item_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mrcs_rsp_type        rsp_ff, rsp_in;

   logic                cfg_err;
   logic [AW-1:0]       col_clamp;
   logic                row_end_a;
   logic                matrix_end_a;
   logic                out_free;
   logic                s1_has_rsp;
   logic                s1_go;
   logic                s1_to_drain;
   logic                accept;
   logic [SUM_W-1:0]    elem_ext;
   logic [SUM_W-1:0]    col_sum;
   logic [SUM_W-1:0]    row_sum;
   logic                drain_go;
   logic                drain_last;

   assign cfg_err = (cfg.num_rows == '0) || (cfg.num_cols == '0) ||
                    ({1'b0, cfg.num_cols} > MAX_COLS_W);

   assign col_clamp = ({1'b0, col_pos_ff} >= MAX_COLS_W) ? LAST_COL
                                                         : AW'(col_pos_ff);
   assign row_end_a    = ({1'b0, col_pos_ff} + 1'b1) >= {1'b0, cfg.num_cols};
   assign matrix_end_a = ({1'b0, row_pos_ff} + 1'b1) >= {1'b0, cfg.num_rows};

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s1_has_rsp  = s1_item_ff.err || s1_item_ff.row_end;
   assign s1_go       = s1_valid_ff && (!s1_has_rsp || out_free);
   assign s1_to_drain = s1_go && !s1_item_ff.err && s1_item_ff.matrix_end;

   assign req_tready = (state_ff == ST_RUN) && (!s1_valid_ff || (s1_go && !s1_to_drain));
   assign accept     = req_tvalid && req_tready;

   assign elem_ext = {{(SUM_W-ELEM_W){s1_elem_ff[ELEM_W-1]}}, s1_elem_ff};
   assign col_sum  = (s1_item_ff.first_row ? '0 : mem_rdata) + elem_ext;
   assign row_sum  = row_total_ff + elem_ext;

   assign drain_go   = (state_ff == ST_DRAIN) && out_free;
   assign drain_last = ((COLS_W+1)'(drain_idx_ff) + 1'b1) == {1'b0, cfg.num_cols};

   always_comb begin
      state_in     = state_ff;
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      row_total_in = row_total_ff;
      drain_idx_in = drain_idx_ff;
      s1_valid_in  = s1_valid_ff;
      s1_elem_in   = s1_elem_ff;
      s1_col_in    = s1_col_ff;
      s1_item_in   = s1_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = s1_col_ff;
      mem_wdata    = col_sum;
      mem_re       = 1'b0;
      mem_raddr    = col_clamp;

      unique case (state_ff)
         ST_RUN: begin
            if (s1_go) begin
               s1_valid_in = 1'b0;
               if (!s1_item_ff.err) begin
                  mem_we       = 1'b1;
                  row_total_in = s1_item_ff.row_end ? '0 : row_sum;
               end
               if (s1_item_ff.err) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = SUM_ERR;
                  rsp_in.index = '0;
                  rsp_in.value = '0;
                  rsp_in.last  = 1'b1;
               end else if (s1_item_ff.row_end) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = SUM_ROW;
                  rsp_in.index = s1_item_ff.row_idx;
                  rsp_in.value = row_sum;
                  rsp_in.last  = !s1_item_ff.matrix_end;
               end
               if (s1_to_drain) begin
                  // first column read goes out alongside the final write
                  state_in     = ST_DRAIN;
                  drain_idx_in = '0;
                  mem_re       = 1'b1;
                  mem_raddr    = '0;
               end
            end
            if (accept) begin
               s1_valid_in          = 1'b1;
               s1_elem_in           = req_element;
               s1_col_in            = col_clamp;
               s1_item_in.err       = cfg_err;
               s1_item_in.first_row = (row_pos_ff == '0);
               s1_item_in.row_end   = row_end_a;
               s1_item_in.matrix_end = row_end_a && matrix_end_a;
               s1_item_in.row_idx   = row_pos_ff;
               mem_re               = 1'b1;
               mem_raddr            = col_clamp;
               if (!cfg_err) begin
                  if (!row_end_a) begin
                     col_pos_in = col_pos_ff + 1'b1;
                  end else begin
                     col_pos_in = '0;
                     row_pos_in = matrix_end_a ? '0 : row_pos_ff + 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (drain_go) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = SUM_COL;
               rsp_in.index = INDEX_W'(drain_idx_ff);
               rsp_in.value = mem_rdata;
               rsp_in.last  = drain_last;
               if (drain_last) begin
                  state_in = ST_RUN;
               end else begin
                  drain_idx_in = drain_idx_ff + 1'b1;
                  mem_re       = 1'b1;
                  mem_raddr    = drain_idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         row_total_ff <= '0;
         drain_idx_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         row_total_ff <= row_total_in;
         drain_idx_ff <= drain_idx_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_elem_ff <= s1_elem_in;
      s1_col_ff  <= s1_col_in;
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   a_no_req_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> !req_tready)
      else $error("request taken during column drain");

   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> !mem_we)
      else $error("column store written during drain");

   a_stage_not_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!s1_valid_ff || s1_go))
      else $error("stage holds an item that is not moving on");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (drain_go && drain_last) |=> (state_ff == ST_RUN))
      else $error("drain did not end after last column");

   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      s1_to_drain |=> (state_ff == ST_DRAIN && rsp_tvalid))
      else $error("final row did not start the drain");

endmodule

// File: rtl/matrix_row_col_sums_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_row_col_sums_top
// Row sums per row and column sums after the final row of a streamed matrix.
//
//   channel  direction  handshake                      payload
//   req      in         req_tvalid / req_tready        tdata: element
//   rsp      out        rsp_tvalid / rsp_tready        tdata: index, value;
//                                                      tuser: kind; tlast
//   csr      in/out     psel, penable, pwrite, pready  num_rows @0, num_cols @4
//
// One element per cycle unless held off as below; each element passes through the
// column store read-modify-write stage, bypassed when consecutive elements hit one entry.
// After the final row the input is held off while the last element is written
// back and then while the column totals are read out one by one.
// A row sum or error waiting on rsp_tready holds the stage and the input.
// Reset is synchronous; no clearing pass, the first row writes the store.
// ----------------------------------------------------------------------------
module matrix_row_col_sums_top import mrcs_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,    // [31:0] element
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,    // [15:0] sum_index, [55:16] sum_value
   output logic [1:0]            rsp_tuser,    // [1:0] sum_kind
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   mrcs_cfg_type     cfg;
   mrcs_rsp_type     rsp_item;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [SUM_W-1:0] mem_wdata;
   logic             mem_re;
   logic [AW-1:0]    mem_raddr;
   logic [SUM_W-1:0] mem_rdata;

   mrcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mrcs_col_mem #(.MAX_COLS(MAX_COLS)) u_col_mem (
      .clock (clock),
      .reset (reset),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mrcs_ctrl #(.MAX_COLS(MAX_COLS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_element (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_item    (rsp_item),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata)
   );

   assign rsp_tdata = {rsp_item.value, rsp_item.index};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams matrix elements into matrix_row_col_sums_top and checks every
// row sum, column sum and dimension error against an in-bench predictor.
// Dimensions are set over the register port between phases; the phases
// vary idling on both sides and hold off the receiver.
// ----------------------------------------------------------------------------
module testbench;
   import mrcs_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_CYCLES = 8;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata   = '0;     // [31:0] element
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [55:0]           rsp_tdata;            // [15:0] sum_index, [55:16] sum_value
   logic [1:0]            rsp_tuser;            // [1:0] sum_kind
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [SUM_W-1:0]  col_store [MAX_COLS_DEF];
   logic [SUM_W-1:0]  row_acc   = '0;
   logic [ROWS_W-1:0] row_pos   = '0;
   logic [COLS_W-1:0] col_pos   = '0;
   logic [ROWS_W-1:0] cfg_rows  = 16'd1;
   logic [COLS_W-1:0] cfg_cols  = 6'd1;

   mrcs_rsp_type  sums_expected [$];
   logic [31:0]   elements_pending [$];
   int            elements_queued   = 0;
   int            elements_accepted = 0;
   int            fault_count       = 0;
   int            tx_idle_pct       = 0;
   int            rx_stall_pct      = 0;
   int            holds_requested   = 0;
   int            holds_granted     = 0;
   int            hold_left         = 0;

   matrix_row_col_sums_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic void note_fault(input string what);
      if (fault_count < 10) begin
         $display("%s", what);
      end
      fault_count++;
   endfunction

   // works out the sums that one accepted element releases
   function automatic void accumulate_element(input logic [ELEM_W-1:0] element);
      logic [SUM_W-1:0] ext;
      int               slot;
      bit               matrix_done;
      mrcs_rsp_type     entry;
      if (cfg_rows == 0 || cfg_cols == 0 || int'(cfg_cols) > MAX_COLS_DEF) begin
         entry.kind  = SUM_ERR;
         entry.index = '0;
         entry.value = '0;
         entry.last  = 1'b1;
         sums_expected.push_back(entry);
         return;
      end
      ext  = {{(SUM_W-ELEM_W){element[ELEM_W-1]}}, element};
      slot = (int'(col_pos) >= MAX_COLS_DEF) ? MAX_COLS_DEF - 1 : int'(col_pos);
      row_acc = row_acc + ext;
      if (row_pos == 0) begin
         col_store[slot] = ext;
      end else begin
         col_store[slot] = col_store[slot] + ext;
      end
      if (int'(col_pos) + 1 < int'(cfg_cols)) begin
         col_pos = col_pos + 1'b1;
         return;
      end
      matrix_done = (int'(row_pos) + 1 >= int'(cfg_rows));
      entry.kind  = SUM_ROW;
      entry.index = row_pos;
      entry.value = row_acc;
      entry.last  = !matrix_done;
      sums_expected.push_back(entry);
      row_acc = '0;
      col_pos = '0;
      if (!matrix_done) begin
         row_pos = row_pos + 1'b1;
         return;
      end
      for (int j = 0; j < int'(cfg_cols) && j < MAX_COLS_DEF; j++) begin
         entry.kind  = SUM_COL;
         entry.index = INDEX_W'(j);
         entry.value = col_store[j];
         entry.last  = (j + 1 == int'(cfg_cols));
         sums_expected.push_back(entry);
      end
      row_pos = '0;
   endfunction

   // driver: offers queued elements, holding each until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (elements_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= elements_pending.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver ready, with long hold-offs on demand
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_granted != holds_requested) begin
         rsp_tready    <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         holds_granted <= holds_granted + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // monitor: predicts on each accepted request, then checks each result
   always @(posedge clock) begin : monitor
      mrcs_rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accumulate_element(req_tdata);
            elements_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (sums_expected.size() == 0) begin
               note_fault($sformatf("unexpected result: kind %0d index %0d value %0d last %0b",
                  rsp_tuser, rsp_tdata[15:0], $signed(rsp_tdata[55:16]), rsp_tlast));
            end else begin
               want = sums_expected.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata[15:0] !== want.index ||
                   rsp_tdata[55:16] !== want.value || rsp_tlast !== want.last) begin
                  note_fault($sformatf({"result mismatch: expected kind %0d index %0d ",
                     "value %0d last %0b, got kind %0d index %0d value %0d last %0b"},
                     want.kind, want.index, want.value, want.last, rsp_tuser,
                     rsp_tdata[15:0], $signed(rsp_tdata[55:16]), rsp_tlast));
               end
            end
         end
      end
   end

   task automatic csr_access(input csr_reg_type which, input logic write,
                             input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(which));
      csr_pwdata  <= write ? value : '0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (!write && csr_prdata !== value) begin
         note_fault($sformatf("register read mismatch at %0d: expected %h, got %h",
            4 * int'(which), value, csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (write) begin
         case (which)
            CSR_NUM_ROWS: cfg_rows = value[ROWS_W-1:0];
            CSR_NUM_COLS: cfg_cols = value[COLS_W-1:0];
         endcase
      end
   endtask

   task automatic queue_element(input logic [31:0] element);
      elements_pending.push_back(element);
      elements_queued++;
   endtask

   // waits out every outstanding request and result, then lets the stage settle
   task automatic wait_quiet();
      while (elements_accepted != elements_queued || sums_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_dims(input logic [ROWS_W-1:0] rows, input logic [COLS_W-1:0] cols);
      csr_reg_type which;
      wait_quiet();
      csr_access(CSR_NUM_ROWS, 1'b1, {16'($urandom), rows});
      csr_access(CSR_NUM_COLS, 1'b1, {26'($urandom), cols});
      which = csr_reg_type'($urandom_range(1));
      csr_access(which, 1'b0, (which == CSR_NUM_ROWS) ? {16'd0, cfg_rows} : {26'd0, cfg_cols});
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
         1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
         2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
         default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
   endtask

   function automatic logic [31:0] pick_element();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'(int'($urandom_range(16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0]       corner [5];
      logic [ROWS_W-1:0] rows;
      logic [COLS_W-1:0] cols;
      int                count;
      corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset dimensions are one by one: every element closes a matrix
      foreach (corner[i]) queue_element(corner[i]);

      // bad dimensions: zero rows, zero columns, too many columns
      set_dims(16'd0, 6'd4);
      queue_element(32'h1234_5678);
      queue_element(32'h8000_0000);
      set_dims(16'd3, 6'd0);
      queue_element(32'h7FFF_FFFF);
      set_dims(16'd3, 6'd63);
      queue_element(32'hFFFF_FFFF);
      set_dims(16'd3, 6'd33);
      queue_element(32'h0000_0001);

      set_dims(16'd2, 6'd3);
      repeat (3) queue_element(32'h7FFF_FFFF);
      repeat (3) queue_element(32'h8000_0000);

      // shrink both dimensions in the middle of the second row
      set_dims(16'd3, 6'd3);
      queue_element(32'h0000_0001);
      queue_element(32'hFFFF_FFFF);
      queue_element(32'h7FFF_FFFF);
      queue_element(32'h8000_0000);
      set_dims(16'd2, 6'd2);
      queue_element(32'h0000_0005);

      // one full-width row fills every column entry
      set_dims(16'd1, 6'd32);
      set_idling(3);
      repeat (32) queue_element(pick_element());

      // a tall single-column matrix sent in two batches;
      // the receiver holds off so the block backs up into the input
      set_dims(16'd60, 6'd1);
      set_idling(0);
      holds_requested++;
      repeat (30) queue_element(($urandom_range(31) == 0) ? $urandom : 32'h8000_0000);
      wait_quiet();
      repeat (30) queue_element(($urandom_range(31) == 0) ? $urandom : 32'h8000_0000);

      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(9))
            0:       rows = 16'd0;
            1:       rows = 16'hFFFF;
            2:       rows = 16'($urandom);
            default: rows = 16'($urandom_range(1, 5));
         endcase
         case ($urandom_range(9))
            0:       cols = 6'd0;
            1:       cols = 6'($urandom_range(33, 63));
            2:       cols = 6'd32;
            default: cols = 6'($urandom_range(1, 8));
         endcase
         set_dims(rows, cols);
         set_idling(phase % 4);
         if (rows == 0 || cols == 0 || int'(cols) > MAX_COLS_DEF) begin
            count = $urandom_range(1, 4);
         end else if (int'(rows) * int'(cols) <= 24) begin
            count = int'(rows) * int'(cols);
         end else begin
            count = $urandom_range(1, 24);
         end
         repeat (count) queue_element(pick_element());
      end

      wait_quiet();
      repeat (32) @(posedge clock);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #400_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
